/* sv/mlr_pkg.sv */
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types and constants for the midpoint line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mlr_pkg;

  localparam int CoordBits = 10;
  localparam int ColorBits = 4;
  // decision stays within +/- 2*major_delta, plus sign and headroom
  localparam int DecBits   = CoordBits + 3;

  localparam logic [ColorBits-1:0] ColorReset = ColorBits'(3);

  typedef enum logic {
    ModeStart   = 1'b0,
    ModeAdvance = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e                mode;
    logic [CoordBits-1:0] x_start;
    logic [CoordBits-1:0] y_start;
    logic [CoordBits-1:0] x_end;
    logic [CoordBits-1:0] y_end;
  } line_item_t;

  typedef struct packed {
    logic                 pixel_valid;
    logic [CoordBits-1:0] pixel_x;
    logic [CoordBits-1:0] pixel_y;
    logic [ColorBits-1:0] pixel_color;
    logic                 last_pixel;
  } pixel_t;

  typedef struct packed {
    logic active;
  } walk_status_t;

endpackage

`default_nettype wire

/* sv/mlr_walk.sv */
// ----------------------------------------------------------------------------
// mlr_walk
// Line walk state and next-pixel logic: setup on start, one step per advance while a line is active.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_walk (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire mlr_pkg::line_item_t          item_i,
  input  wire logic [mlr_pkg::ColorBits-1:0] color_i,
  output mlr_pkg::pixel_t                   pixel_o,
  output mlr_pkg::walk_status_t             status_o
);

  localparam int CB  = mlr_pkg::CoordBits;
  localparam int DB  = mlr_pkg::DecBits;
  localparam int Pad = DB - CB;

  logic [CB-1:0]        col_q, col_d;
  logic [CB-1:0]        row_q, row_d;
  logic signed [DB-1:0] dec_q, dec_d;
  logic [CB-1:0]        steps_q, steps_d;
  logic [CB-1:0]        major_q, major_d;
  logic [CB-1:0]        minor_q, minor_d;
  logic                 steep_q, steep_d;
  logic                 down_q, down_d;
  logic                 active_q, active_d;

  // setup terms
  logic [CB-1:0] adx, ady, sx, sy, fx, fy, s_major, s_minor;
  logic          s_steep, s_swap, s_down;
  // walk terms
  logic          diag;
  logic [CB-1:0] maj_pos, min_pos, maj_nxt, min_nxt;

  always_comb begin
    adx     = (item_i.x_start > item_i.x_end) ? item_i.x_start - item_i.x_end
                                              : item_i.x_end - item_i.x_start;
    ady     = (item_i.y_start > item_i.y_end) ? item_i.y_start - item_i.y_end
                                              : item_i.y_end - item_i.y_start;
    s_steep = (ady >= adx);
    s_swap  = s_steep ? (item_i.y_end < item_i.y_start) : (item_i.x_end < item_i.x_start);
    sx      = s_swap ? item_i.x_end   : item_i.x_start;
    sy      = s_swap ? item_i.y_end   : item_i.y_start;
    fx      = s_swap ? item_i.x_start : item_i.x_end;
    fy      = s_swap ? item_i.y_start : item_i.y_end;
    s_major = s_steep ? ady : adx;
    s_minor = s_steep ? adx : ady;
    s_down  = s_steep ? (fx < sx) : (fy < sy);

    // shallow lines stay straight on a tie, steep lines go diagonal
    diag    = steep_q ? (dec_q[DB-1] || (dec_q == '0)) : dec_q[DB-1];
    maj_pos = steep_q ? row_q : col_q;
    min_pos = steep_q ? col_q : row_q;
    maj_nxt = maj_pos + CB'(1);
    min_nxt = !diag ? min_pos : (down_q ? min_pos - CB'(1) : min_pos + CB'(1));
  end

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    dec_d    = dec_q;
    steps_d  = steps_q;
    major_d  = major_q;
    minor_d  = minor_q;
    steep_d  = steep_q;
    down_d   = down_q;
    active_d = active_q;
    pixel_o  = '0;

    if (item_i.mode == mlr_pkg::ModeStart) begin
      col_d    = sx;
      row_d    = sy;
      major_d  = s_major;
      minor_d  = s_minor;
      steep_d  = s_steep;
      down_d   = s_down;
      steps_d  = s_major;
      active_d = (s_major != '0);
      dec_d    = $signed({{Pad{1'b0}}, s_major}) - $signed({{(Pad-1){1'b0}}, s_minor, 1'b0});
      pixel_o.pixel_valid = 1'b1;
      pixel_o.pixel_x     = sx;
      pixel_o.pixel_y     = sy;
      pixel_o.pixel_color = color_i;
      pixel_o.last_pixel  = (s_major == '0);
    end else if (active_q) begin
      col_d    = steep_q ? min_nxt : maj_nxt;
      row_d    = steep_q ? maj_nxt : min_nxt;
      steps_d  = steps_q - CB'(1);
      active_d = (steps_q != CB'(1));
      if (diag) begin
        dec_d = dec_q + $signed({{(Pad-1){1'b0}}, major_q - minor_q, 1'b0});
      end else begin
        dec_d = dec_q - $signed({{(Pad-1){1'b0}}, minor_q, 1'b0});
      end
      pixel_o.pixel_valid = 1'b1;
      pixel_o.pixel_x     = col_d;
      pixel_o.pixel_y     = row_d;
      pixel_o.pixel_color = color_i;
      pixel_o.last_pixel  = (steps_q == CB'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      dec_q    <= '0;
      steps_q  <= '0;
      major_q  <= '0;
      minor_q  <= '0;
      steep_q  <= 1'b0;
      down_q   <= 1'b0;
      active_q <= 1'b0;
    end else if (step_i) begin
      col_q    <= col_d;
      row_q    <= row_d;
      dec_q    <= dec_d;
      steps_q  <= steps_d;
      major_q  <= major_d;
      minor_q  <= minor_d;
      steep_q  <= steep_d;
      down_q   <= down_d;
      active_q <= active_d;
    end
  end

  assign status_o.active = active_q;

endmodule

`default_nettype wire

/* sv/midpoint_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Integer midpoint line walker, one pixel per item, all four slope cases.
// ----------------------------------------------------------------------------
// A start item loads two endpoints and returns the first pixel; each advance
// item returns the next pixel, with last_pixel set on the far endpoint and an
// all-zero result once the line is done. The walk state advances at the edge
// the item is accepted and its pixel lands in the output register, so results
// appear in the cycle after acceptance and a new item is accepted every cycle
// while that register is empty or being drained.
// The color register, set over the cfg channel, is sampled when an item is accepted.
`default_nettype none

module midpoint_line_rasterizer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [mlr_pkg::ColorBits-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire mlr_pkg::line_item_t           in_data_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      mlr_pkg::pixel_t               out_data_o
);

  logic [mlr_pkg::ColorBits-1:0] color_q;
  logic                          out_valid_q, out_valid_d;
  mlr_pkg::pixel_t               out_data_q;
  mlr_pkg::pixel_t               pixel;
  mlr_pkg::walk_status_t         status;
  logic                          in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;

  mlr_walk u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_accept),
    .item_i   (in_data_i),
    .color_i  (color_q),
    .pixel_o  (pixel),
    .status_o (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= mlr_pkg::ColorReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      color_q <= cfg_data_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= pixel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // start item always yields a drawn pixel
  a_start_draws: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (in_data_i.mode == mlr_pkg::ModeStart)
    |=> out_valid_o && out_data_o.pixel_valid)
    else $error("start item did not produce a pixel");

  // final endpoint ends the walk
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_accept) && out_data_o.last_pixel |-> !status.active)
    else $error("walk still active after last pixel");

  // advance with no line in progress gives an empty result
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (in_data_i.mode == mlr_pkg::ModeAdvance) && !status.active
    |=> !out_data_o.pixel_valid && !out_data_o.last_pixel)
    else $error("pixel emitted with no active line");

endmodule

`default_nettype wire

/* verif/mlr_pixel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlr_pixel_checker
// Watches the rasterizer channels, walks each line itself and checks pixels.
// ----------------------------------------------------------------------------
// Every accepted input item queues the pixel it must produce; every accepted
// output item is compared field by field with the oldest queued pixel.

module mlr_pixel_checker
  import mlr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [ColorBits-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  line_item_t           in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  pixel_t               out_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  logic [ColorBits-1:0] color;
  logic [CoordBits-1:0] col, row, major_d, minor_d;
  logic [CoordBits:0]   steps_left;
  int                   decision;
  logic                 steep, minor_down, active;
  pixel_t               pixels_due[$];
  int                   fails = 0;

  function automatic string show(input pixel_t px);
    return $sformatf("valid=%0d x=%0d y=%0d color=%0d last=%0d", px.pixel_valid,
                     px.pixel_x, px.pixel_y, px.pixel_color, px.last_pixel);
  endfunction

  // Advances the walk by one item and returns the pixel it produces.
  function automatic pixel_t walk_line(input line_item_t it);
    pixel_t               px;
    logic [CoordBits-1:0] adx, ady, fx, fy, maj, mnr;
    logic                 diag;
    px = '0;
    if (it.mode == ModeAdvance && !active) return px;
    if (it.mode == ModeStart) begin
      adx = (it.x_start > it.x_end) ? it.x_start - it.x_end : it.x_end - it.x_start;
      ady = (it.y_start > it.y_end) ? it.y_start - it.y_end : it.y_end - it.y_start;
      steep = (ady >= adx);
      // start from the end with the smaller major coordinate
      if (steep ? (it.y_end < it.y_start) : (it.x_end < it.x_start)) begin
        col = it.x_end;   row = it.y_end;   fx = it.x_start; fy = it.y_start;
      end else begin
        col = it.x_start; row = it.y_start; fx = it.x_end;   fy = it.y_end;
      end
      if (steep) begin
        major_d = ady; minor_d = adx; minor_down = (fx < col);
      end else begin
        major_d = adx; minor_d = ady; minor_down = (fy < row);
      end
      decision   = int'(major_d) - 2 * int'(minor_d);
      steps_left = {1'b0, major_d};
      active     = (major_d != 0);
    end else begin
      // shallow lines stay straight on a tie, steep ones go diagonal
      diag = steep ? (decision <= 0) : (decision < 0);
      maj  = steep ? row : col;
      mnr  = steep ? col : row;
      maj  = maj + 1'b1;
      if (diag) begin
        mnr      = minor_down ? mnr - 1'b1 : mnr + 1'b1;
        decision = decision + 2 * (int'(major_d) - int'(minor_d));
      end else begin
        decision = decision - 2 * int'(minor_d);
      end
      if (steep) begin
        row = maj; col = mnr;
      end else begin
        col = maj; row = mnr;
      end
      steps_left = steps_left - 1'b1;
      active     = (steps_left != 0);
    end
    px.pixel_valid = 1'b1;
    px.pixel_x     = col;
    px.pixel_y     = row;
    px.pixel_color = color;
    px.last_pixel  = (steps_left == 0);
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    pixel_t want;
    if (!rst_ni) begin
      color      = ColorReset;
      col        = '0;
      row        = '0;
      major_d    = '0;
      minor_d    = '0;
      steps_left = '0;
      decision   = 0;
      steep      = 1'b0;
      minor_down = 1'b0;
      active     = 1'b0;
      pixels_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) color = cfg_data_i;
      // the pixel leaving now always belongs to an earlier item
      if (out_valid_i && out_ready_i) begin
        if (pixels_due.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected pixel item: got %s", show(out_data_i));
        end else begin
          want = pixels_due.pop_front();
          if (out_data_i.pixel_valid !== want.pixel_valid ||
              out_data_i.pixel_x     !== want.pixel_x     ||
              out_data_i.pixel_y     !== want.pixel_y     ||
              out_data_i.pixel_color !== want.pixel_color ||
              out_data_i.last_pixel  !== want.last_pixel) begin
            fails++;
            if (fails <= 10)
              $display("pixel mismatch at %0t: expected %s, got %s", $realtime,
                       show(want), show(out_data_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) pixels_due.push_back(walk_line(in_data_i));
    end
    pending_o    <= pixels_due.size();
    fail_count_o <= fails;
  end

endmodule

/* verif/midpoint_line_rasterizer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_tb
// Line walks in all slope cases under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
// A directed set covers ties, single points, reversed and clipped walks; then
// random lines, mostly short and fully walked, with color changes between
// phases. The checker beside the block predicts and compares every pixel.

module midpoint_line_rasterizer_tb;
  import mlr_pkg::*;

  localparam int CoordMax   = 2**CoordBits - 1;
  localparam int ItemTarget = 1700;
  localparam int PhaseItems = 280;
  localparam int HoldAtItem = 600;
  localparam int HoldCycles = 250;
  localparam int StuckLimit = 2000;

  typedef enum int {RxFree, RxCoin, RxSparse, RxPattern} stall_style_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [ColorBits-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  line_item_t           in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  pixel_t               out_data;
  int                   fail_cnt;
  int                   pixels_owed;
  int                   items_sent = 0;
  int                   burst_left = 0;
  int                   stuck_cycles = 0;
  bit                   hold_done = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  midpoint_line_rasterizer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  mlr_pixel_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_cnt),
    .pending_o    (pixels_owed)
  );

  function automatic line_item_t start_item(input int xs, ys, xe, ye);
    line_item_t it;
    it.mode    = ModeStart;
    it.x_start = CoordBits'(xs);
    it.y_start = CoordBits'(ys);
    it.x_end   = CoordBits'(xe);
    it.y_end   = CoordBits'(ye);
    return it;
  endfunction

  // coordinates of an advance item are don't-care, so they carry noise
  function automatic line_item_t advance_item();
    line_item_t it;
    it.mode    = ModeAdvance;
    it.x_start = CoordBits'($urandom_range(0, CoordMax));
    it.y_start = CoordBits'($urandom_range(0, CoordMax));
    it.x_end   = CoordBits'($urandom_range(0, CoordMax));
    it.y_end   = CoordBits'($urandom_range(0, CoordMax));
    return it;
  endfunction

  function automatic int far_coord(input int c, input int d);
    int f;
    f = $urandom_range(0, 1) ? c + d : c - d;
    if (f < 0) f = c + d;
    else if (f > CoordMax) f = c - d;
    return f;
  endfunction

  task automatic offer(input line_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic draw_line(input int xs, ys, xe, ye, input int advances);
    offer(start_item(xs, ys, xe, ye));
    repeat (advances) offer(advance_item());
  endtask

  // color is only changed once every queued pixel has come out
  task automatic set_color(input int c);
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pixels_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= ColorBits'(c);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int kind, reach, phase, next_phase;
    int xs, ys, xe, ye, dx, dy, major, steps;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset color in use
    offer(advance_item());                  // advance with no line loaded
    draw_line(5, 5, 5, 5, 1);               // single point, then past the end
    draw_line(0, 1023, 4, 1021, 5);         // shallow, minor axis going down
    draw_line(1023, 1023, 1020, 1019, 4);   // steep, endpoints swapped
    draw_line(13, 7, 10, 10, 1);            // equal slopes, cut short
    draw_line(0, 0, 1023, 1023, 2);         // restarts a line in progress
    draw_line(0, 0, 2, 1, 2);               // shallow tie stays straight
    draw_line(0, 0, 1, 2, 2);               // steep tie goes diagonal

    phase      = 0;
    next_phase = items_sent + PhaseItems;
    while (items_sent < ItemTarget) begin
      if (items_sent >= next_phase) begin
        phase++;
        set_color((phase == 1) ? 15 : (phase == 2) ? 0 : $urandom_range(0, 15));
        next_phase += PhaseItems;
      end
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        repeat ($urandom_range(1, 3)) offer(advance_item());
      end else begin
        xs = $urandom_range(0, CoordMax);
        ys = $urandom_range(0, CoordMax);
        if (kind == 1) begin
          xe = $urandom_range(0, CoordMax);
          ye = $urandom_range(0, CoordMax);
        end else begin
          reach = (kind == 2) ? $urandom_range(0, 200) : $urandom_range(0, 16);
          dx = $urandom_range(0, reach);
          dy = $urandom_range(0, reach);
          if (kind == 3) dy = dx;
          else if (kind == 4) dy = 0;
          else if (kind == 5) dx = 0;
          xe = far_coord(xs, dx);
          ye = far_coord(ys, dy);
        end
        dx    = (xs > xe) ? xs - xe : xe - xs;
        dy    = (ys > ye) ? ys - ye : ye - ys;
        major = (dx > dy) ? dx : dy;
        steps = major;
        if (kind == 1) begin
          steps = $urandom_range(0, 30);
          if (steps > major) steps = major;
        end else if ($urandom_range(0, 7) == 0) begin
          steps = $urandom_range(0, major);
        end
        if ($urandom_range(0, 3) == 0) steps += $urandom_range(1, 2);
        draw_line(xs, ys, xe, ye, steps);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : rx_stalls
    stall_style_e style;
    int           seg_len, tick;
    tick = 0;
    forever begin
      style   = stall_style_e'($urandom_range(0, 3));
      seg_len = $urandom_range(8, 120);
      repeat (seg_len) begin
        @(posedge clk);
        tick++;
        if (!hold_done && items_sent >= HoldAtItem) begin
          // long hold-off so the block backs up into its input
          hold_done = 1'b1;
          out_ready <= 1'b0;
          repeat (HoldCycles) @(posedge clk);
        end else begin
          case (style)
            RxFree:   out_ready <= 1'b1;
            RxCoin:   out_ready <= 1'($urandom_range(0, 1));
            RxSparse: out_ready <= ($urandom_range(0, 3) == 0);
            default:  out_ready <= ((tick % 8) < 5);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= StuckLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

/* sim.f */
sv/mlr_pkg.sv
sv/mlr_walk.sv
sv/midpoint_line_rasterizer.sv
verif/mlr_pixel_checker.sv
verif/midpoint_line_rasterizer_tb.sv
